// ===== sv/b2d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_pkg: shared types for the binary to decimal digit converter
// Transfer structs, digit cell controls and controller states.
// ----------------------------------------------------------------------------
package b2d_pkg;

	localparam logic [5:0] ASCII_ZERO = 6'd48;

	typedef struct packed {
		logic [63:0] value_high;
		logic [63:0] value_low;
	} b2d_in_t;

	typedef struct packed {
		logic [5:0] digit_char;
		logic       last_digit;
	} b2d_out_t;

	// Controls broadcast to every digit cell
	typedef struct packed {
		logic clear;        // zero the digit
		logic dabble;       // add-3 correction, then shift one binary bit in
		logic digit_shift;  // take the lower neighbor's digit
	} b2d_cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_EMIT
	} b2d_state_t;

endpackage

// ===== sv/binary_to_decimal_digits.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_digits: unsigned binary to ASCII decimal digits
// Double dabble over a chain of BCD digit cells, then digits out MSD first.
// ----------------------------------------------------------------------------
//  channel   signals                    direction  transfer when
//  input     start, busy, value         in         start && !busy
//  result    result_valid, result       out        result_valid (one cycle)
//
//  An accepted value is bit shifted through the cell chain, VALUE_BITS bits,
//  then digit shifted through it, MAX_DIGITS digits, one digit leaving the top
//  cell each cycle (leading zeros dropped). busy is high through the bit and
//  digit shifting, so no new value is taken until the last digit has left.
//  Results are registered, appearing the cycle after the digit leaves the chain.
//  Reset returns the controller to idle; digit contents are don't care.
//  The receiver takes each result as presented; there is no back pressure.
// ----------------------------------------------------------------------------
module binary_to_decimal_digits #(
	parameter int VALUE_BITS = 128,
	parameter int MAX_DIGITS = 39
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  b2d_pkg::b2d_in_t   value,
	output logic               result_valid,
	output b2d_pkg::b2d_out_t  result
);
	import b2d_pkg::*;

	localparam int BW = $clog2(VALUE_BITS);
	localparam int RW = $clog2(MAX_DIGITS + 1);

	b2d_state_t      state_q, state_d;
	logic [BW-1:0]   bit_cnt_q, bit_cnt_d;
	logic [RW-1:0]   rem_q, rem_d;
	logic            seen_q, seen_d;
	logic [VALUE_BITS-1:0] shift_q;
	b2d_out_t        result_q;
	logic            result_valid_q;
	logic            accept;
	logic            emit;
	b2d_cell_ctrl_t  ctrl;

	logic [3:0]      digits [MAX_DIGITS];
	logic            carries [MAX_DIGITS];
	logic [127:0]    value_full;

	assign accept     = start && (state_q == ST_IDLE);
	assign busy       = (state_q != ST_IDLE);
	assign value_full = {value.value_high, value.value_low};

	genvar gi;
	generate
		for (gi = 0; gi < MAX_DIGITS; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				b2d_cell u_cell (
					.clk       (clk),
					.ctrl      (ctrl),
					.carry_in  (shift_q[VALUE_BITS-1]),
					.digit_in  (4'd0),
					.digit     (digits[gi]),
					.carry_out (carries[gi])
				);
			end else begin : g_rest
				b2d_cell u_cell (
					.clk       (clk),
					.ctrl      (ctrl),
					.carry_in  (carries[gi-1]),
					.digit_in  (digits[gi-1]),
					.digit     (digits[gi]),
					.carry_out (carries[gi])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			bit_cnt_q      <= '0;
			rem_q          <= '0;
			seen_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			bit_cnt_q      <= bit_cnt_d;
			rem_q          <= rem_d;
			seen_q         <= seen_d;
			result_valid_q <= emit;
		end
	end

	// binary value shifts out MSB first
	always_ff @(posedge clk) begin
		if (accept) begin
			shift_q <= value_full[VALUE_BITS-1:0];
		end else if (state_q == ST_SHIFT) begin
			shift_q <= {shift_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.digit_char <= ASCII_ZERO + {2'b00, digits[MAX_DIGITS-1]};
			result_q.last_digit <= (rem_q == RW'(1));
		end
	end

	always_comb begin
		state_d          = state_q;
		bit_cnt_d        = bit_cnt_q;
		rem_d            = rem_q;
		seen_d           = seen_q;
		emit             = 1'b0;
		ctrl.clear       = 1'b0;
		ctrl.dabble      = 1'b0;
		ctrl.digit_shift = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctrl.clear = 1'b1;
					bit_cnt_d  = BW'(VALUE_BITS - 1);
					state_d    = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				ctrl.dabble = 1'b1;
				if (bit_cnt_q == '0) begin
					rem_d   = RW'(MAX_DIGITS);
					seen_d  = 1'b0;
					state_d = ST_EMIT;
				end else begin
					bit_cnt_d = bit_cnt_q - 1'b1;
				end
			end
			ST_EMIT: begin
				ctrl.digit_shift = 1'b1;
				// drop leading zeros, but always send the units digit
				emit  = (digits[MAX_DIGITS-1] != 4'd0) || seen_q || (rem_q == RW'(1));
				rem_d = rem_q - 1'b1;
				if (emit) begin
					seen_d = 1'b1;
				end
				if (rem_q == RW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== sv/b2d_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_cell: one BCD digit of the double dabble chain
// Holds one decimal digit; shifts binary bits or whole digits to its neighbor.
// ----------------------------------------------------------------------------
module b2d_cell (
	input  logic                    clk,
	input  b2d_pkg::b2d_cell_ctrl_t ctrl,
	input  logic                    carry_in,
	input  logic [3:0]              digit_in,
	output logic [3:0]              digit,
	output logic                    carry_out
);
	import b2d_pkg::*;

	logic [3:0] digit_q;
	logic [3:0] adj;

	// add 3 when the digit would overflow past 9 on doubling
	assign adj       = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign carry_out = adj[3];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= 4'd0;
		end else if (ctrl.dabble) begin
			digit_q <= {adj[2:0], carry_in};
		end else if (ctrl.digit_shift) begin
			digit_q <= digit_in;
		end
	end

endmodule

// ===== verif/tb_binary_to_decimal_digits.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_digits: self-checking bench for the digit converter
// Feeds 128-bit values (edge values first, then random widths, all-nines and
// shifted all-ones patterns), predicts the ASCII digit string by repeated division by ten, and
// checks every strobed digit in order against the predicted string.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_digits;
	import b2d_pkg::*;

	typedef struct packed {
		logic    drain_first;  // wait for every digit in flight before this one
		logic    calm;         // no idle burst before this transfer
		b2d_in_t data;
	} feed_item_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	b2d_in_t   value = '0;
	logic      busy;
	logic      result_valid;
	b2d_out_t  result;

	feed_item_t  pending_items[$];
	b2d_out_t    digits_due[$];
	int unsigned gap_left = 0;
	int unsigned mismatches = 0;

	binary_to_decimal_digits uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.result_valid (result_valid),
		.result       (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Decimal string of the full 128-bit value, most significant digit first
	function automatic void predict_digits(input b2d_in_t item);
		logic [127:0] rest;
		logic [3:0]   decimals[$];
		b2d_out_t     digit;
		rest = {item.value_high, item.value_low};
		do begin
			decimals.push_front(4'(rest % 128'd10));
			rest = rest / 128'd10;
		end while (rest != '0);
		foreach (decimals[i]) begin
			digit.digit_char = ASCII_ZERO + 6'(decimals[i]);
			digit.last_digit = (i == decimals.size() - 1);
			digits_due.push_back(digit);
		end
	endfunction

	task automatic add_item(input logic [127:0] number, input bit drain, input bit calm);
		feed_item_t item;
		item.drain_first = drain;
		item.calm = calm;
		item.data.value_high = number[127:64];
		item.data.value_low = number[63:0];
		pending_items.push_back(item);
	endtask

	// Driver: one transfer per start && !busy edge, idle bursts counted on idle cycles
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_digits(value);
				void'(pending_items.pop_front());
				if (pending_items.size() != 0 && !pending_items[0].calm &&
						$urandom_range(0, 2) != 0)
					gap_left = $urandom_range(1, 17);
			end else if (!busy && gap_left != 0) begin
				gap_left--;
			end

			if (gap_left == 0 && pending_items.size() != 0 &&
					(!pending_items[0].drain_first ||
					 (digits_due.size() == 0 && !busy && !result_valid))) begin
				start <= 1'b1;
				value <= pending_items[0].data;
			end else begin
				// hold start low and scramble the value, which must be ignored
				start <= 1'b0;
				value <= {$urandom, $urandom, $urandom, $urandom};
			end
		end
	end

	// Monitor: every strobed digit must match the oldest predicted digit
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (digits_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected digit: char %0d last %0d",
						result.digit_char, result.last_digit);
			end else begin
				if (result.digit_char != digits_due[0].digit_char ||
						result.last_digit != digits_due[0].last_digit) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"digit mismatch: expected char %0d last %0d,",
							" got char %0d last %0d"},
							digits_due[0].digit_char, digits_due[0].last_digit,
							result.digit_char, result.last_digit);
				end
				void'(digits_due.pop_front());
			end
		end
	end

	initial begin
		logic [127:0] tens;
		logic [127:0] number;
		int unsigned  width;
		int unsigned  pick;

		tens = 128'd1;
		repeat (38) tens = tens * 128'd10;

		// edge values
		add_item(128'd0, 1'b0, 1'b0);
		add_item(128'd1, 1'b0, 1'b0);
		add_item(128'd9, 1'b0, 1'b0);
		add_item(128'd10, 1'b0, 1'b0);
		add_item(128'd99, 1'b0, 1'b0);
		add_item(128'd100, 1'b0, 1'b0);
		add_item(128'd12345678901234567890, 1'b0, 1'b0);
		add_item({64'd0, {64{1'b1}}}, 1'b0, 1'b0);
		add_item({64'd1, 64'd0}, 1'b1, 1'b0);
		add_item({128{1'b1}}, 1'b0, 1'b0);
		add_item(tens, 1'b0, 1'b0);
		add_item(tens - 128'd1, 1'b0, 1'b0);
		add_item({1'b1, 127'd0}, 1'b0, 1'b0);
		add_item({{64{1'b1}}, 64'd0}, 1'b0, 1'b0);
		add_item({32{4'hA}}, 1'b0, 1'b0);
		add_item({32{4'h5}}, 1'b0, 1'b0);
		add_item(128'd10000000000000000000, 1'b0, 1'b0);

		// random widths, runs of nines, and shifted all-ones patterns
		for (int n = 0; n < 143; n++) begin
			pick = $urandom_range(0, 7);
			if (pick == 0) begin
				number = 128'd1;
				repeat ($urandom_range(0, 38)) number = number * 128'd10;
				number = number - 128'd1;
			end else if (pick == 1) begin
				number = {128{1'b1}} << $urandom_range(0, 127);
			end else begin
				width = $urandom_range(0, 128);
				number = {$urandom, $urandom, $urandom, $urandom};
				if (width < 128)
					number = number & ((128'd1 << width) - 128'd1);
			end
			add_item(number, n == 80, n >= 125);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || digits_due.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		if (mismatches == 0 && digits_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
